FILE: rtl/yrd_pkg.sv
// Shared types, widths and constants for the detection row decoder.
// No dependencies; every other file of the decoder imports this package.
package yrd_pkg;

  // Fixed point format of tensor elements and scores.
  localparam int FRAC_BITS   = 12;
  localparam int MAX_CLASSES = 128;

  localparam int ELEM_W  = 24;
  localparam int POS_W   = 11;
  localparam int CLASS_W = 10;
  localparam int SCORE_W = 23;
  localparam int EDGE_W  = 16;
  localparam int SIZE_W  = 17;
  localparam int PROD_W  = 2 * ELEM_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Row layout: four box elements, then objectness in mode 1, then classes.
  localparam logic [POS_W-1:0] POS_CX    = 11'd0;
  localparam logic [POS_W-1:0] POS_CY    = 11'd1;
  localparam logic [POS_W-1:0] POS_W_RAW = 11'd2;
  localparam logic [POS_W-1:0] POS_H_RAW = 11'd3;
  localparam logic [POS_W-1:0] POS_OBJ   = 11'd4;
  localparam logic [POS_W-1:0] POS_LIMIT = 11'd2047;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y        = 3'd5;

  typedef struct packed {
    logic        decode_mode;
    logic [12:0] conf_threshold;
    logic [13:0] image_width;
    logic [13:0] image_height;
    logic [15:0] scale_x;
    logic [15:0] scale_y;
  } yrd_cfg_t;

  // One kept row, handed from the front end to the box arithmetic.
  typedef struct packed {
    logic [CLASS_W-1:0]       class_index;
    logic [SCORE_W-1:0]       best_score;
    logic signed [ELEM_W-1:0] center_x;
    logic signed [ELEM_W-1:0] center_y;
    logic signed [ELEM_W-1:0] raw_width;
    logic signed [ELEM_W-1:0] raw_height;
  } yrd_row_t;

  // Threshold from unsigned Q1.12 to FRAC_BITS fraction bits, as a signed 25-bit value.
  function automatic logic signed [ELEM_W:0] thr_fixed(input logic [12:0] t);
    logic [ELEM_W:0] w;
    w = {12'd0, t};
    if (FRAC_BITS >= 12) begin
      return $signed(w << (FRAC_BITS - 12));
    end else begin
      return $signed(w >> (12 - FRAC_BITS));
    end
  endfunction

endpackage

FILE: rtl/yrd_ifs.sv
// Stream and configuration interfaces of the detection row decoder.
// Depends on yrd_pkg for the payload widths.
interface yrd_elem_if;
  import yrd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;
  logic                     row_last;
  modport source (output valid, output element_value, output row_last, input ready);
  modport sink (input valid, input element_value, input row_last, output ready);
endinterface

interface yrd_det_if;
  import yrd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CLASS_W-1:0]       class_index;
  logic [SCORE_W-1:0]       best_score;
  logic [EDGE_W-1:0]        box_left;
  logic [EDGE_W-1:0]        box_top;
  logic signed [SIZE_W-1:0] box_width;
  logic signed [SIZE_W-1:0] box_height;
  modport source (output valid, output class_index, output best_score, output box_left,
                  output box_top, output box_width, output box_height, input ready);
  modport sink (input valid, input class_index, input best_score, input box_left,
                input box_top, input box_width, input box_height, output ready);
endinterface

interface yrd_cfg_if;
  import yrd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/yrd_front.sv
// Front end: accepts tensor elements, places them in the row layout and keeps
// the running best class score. Depends on yrd_pkg.
module yrd_front (
  input  logic                             clk,
  input  logic                             rst,
  input  yrd_pkg::yrd_cfg_t                cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [yrd_pkg::ELEM_W-1:0] element_value,
  input  logic                             row_last,
  input  logic                             q_full,
  output logic                             push,
  output yrd_pkg::yrd_row_t                push_row
);
  import yrd_pkg::*;

  localparam logic [PROD_W-1:0] SCORE_RND = (48'd1 << FRAC_BITS) - 48'd1;
  localparam logic signed [PROD_W-1:0] SCORE_MAX = 48'sd8388607;
  localparam logic signed [PROD_W-1:0] SCORE_MIN = -48'sd8388608;

  logic                     advance;
  logic [POS_W-1:0]         pos_cnt;
  logic [POS_W-1:0]         first_class;

  logic                     s1_valid;
  logic                     s1_last;
  logic [POS_W-1:0]         s1_pos;
  logic signed [ELEM_W-1:0] s1_value;

  logic                     s2_valid;
  logic                     s2_last;
  logic                     s2_is_class;
  logic                     s2_has_class;
  logic [CLASS_W-1:0]       s2_class;
  logic signed [ELEM_W-1:0] s2_value;
  logic signed [PROD_W-1:0] s2_prod;

  logic signed [ELEM_W-1:0] center_x;
  logic signed [ELEM_W-1:0] center_y;
  logic signed [ELEM_W-1:0] raw_width;
  logic signed [ELEM_W-1:0] raw_height;
  logic signed [ELEM_W-1:0] objectness;
  logic signed [ELEM_W-1:0] running_best;
  logic [CLASS_W-1:0]       running_class;

  logic                     s1_has_class;
  logic                     s1_is_class;
  logic [POS_W-1:0]         s1_rel;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ELEM_W-1:0] score;
  logic                     better;
  logic signed [ELEM_W-1:0] cand_best;
  logic [CLASS_W-1:0]       cand_class;
  logic signed [ELEM_W:0]   thr;
  logic                     keep;

  // The whole front moves together; it holds only when a finished row meets a full queue.
  assign advance     = !(s2_valid && s2_last && q_full);
  assign in_ready    = advance;
  assign first_class = POS_OBJ + POS_W'(cfg.decode_mode);
  assign thr         = thr_fixed(cfg.conf_threshold);

  assign s1_rel       = s1_pos - first_class;
  assign s1_has_class = (s1_pos >= first_class);
  assign s1_is_class  = s1_has_class && (s1_rel < POS_W'(MAX_CLASSES));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt  <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      if (in_valid) begin
        if (row_last) begin
          pos_cnt <= '0;
        end else if (pos_cnt != POS_LIMIT) begin
          pos_cnt <= pos_cnt + 11'd1;
        end
      end
    end
  end

  // Stage one: capture box elements and objectness, form the objectness product.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= '0;
      center_y   <= '0;
      raw_width  <= '0;
      raw_height <= '0;
      objectness <= '0;
    end else if (advance && s1_valid) begin
      case (s1_pos)
        POS_CX:    center_x   <= s1_value;
        POS_CY:    center_y   <= s1_value;
        POS_W_RAW: raw_width  <= s1_value;
        POS_H_RAW: raw_height <= s1_value;
        POS_OBJ: begin
          if (cfg.decode_mode) begin
            objectness <= s1_value;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_last      <= row_last;
      s1_pos       <= pos_cnt;
      s1_value     <= element_value;
      s2_last      <= s1_last;
      s2_is_class  <= s1_is_class;
      s2_has_class <= s1_has_class;
      s2_class     <= s1_rel[CLASS_W-1:0];
      s2_value     <= s1_value;
      s2_prod      <= PROD_W'(s1_value) * PROD_W'(objectness);
    end
  end

  // Stage two: scale the product back, compare against the running best.
  always_comb begin
    prod_rnd = s2_prod + (s2_prod[PROD_W-1] ? $signed(SCORE_RND) : '0);
    prod_sh  = prod_rnd >>> FRAC_BITS;
    if (!cfg.decode_mode) begin
      score = s2_value;
    end else if (prod_sh > SCORE_MAX) begin
      score = SCORE_MAX[ELEM_W-1:0];
    end else if (prod_sh < SCORE_MIN) begin
      score = SCORE_MIN[ELEM_W-1:0];
    end else begin
      score = prod_sh[ELEM_W-1:0];
    end
    better     = s2_is_class && (score > running_best);
    cand_best  = better ? score : running_best;
    cand_class = better ? s2_class : running_class;
    keep = s2_has_class
        && !(cfg.decode_mode && ($signed({objectness[ELEM_W-1], objectness}) < thr))
        && ($signed({cand_best[ELEM_W-1], cand_best}) >= thr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_best  <= '0;
      running_class <= '0;
    end else if (advance && s2_valid) begin
      if (s2_last) begin
        running_best  <= '0;
        running_class <= '0;
      end else begin
        running_best  <= cand_best;
        running_class <= cand_class;
      end
    end
  end

  // Box registers are read here before a following row's first element overwrites them.
  assign push                 = advance && s2_valid && s2_last && keep;
  assign push_row.class_index = cand_class;
  assign push_row.best_score  = cand_best[SCORE_W-1:0];
  assign push_row.center_x    = center_x;
  assign push_row.center_y    = center_y;
  assign push_row.raw_width   = raw_width;
  assign push_row.raw_height  = raw_height;

endmodule

FILE: rtl/yrd_queue.sv
// Four-entry queue of kept rows between the front end and the box arithmetic.
// Depends on yrd_pkg for the row record type.
module yrd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  yrd_pkg::yrd_row_t push_row,
  output logic              full,
  output logic              head_valid,
  input  logic              pop,
  output yrd_pkg::yrd_row_t head_row
);
  import yrd_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  yrd_row_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_pop;

  assign full       = (count == (PTR_W + 1)'(DEPTH));
  assign head_valid = (count != '0);
  assign head_row   = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/yrd_back.sv
// Back end: turns a kept row into the box corner and size in image pixels,
// over three registered stages ending in the output register. Depends on yrd_pkg.
module yrd_back (
  input  logic                             clk,
  input  logic                             rst,
  input  yrd_pkg::yrd_cfg_t                cfg,
  input  logic                             head_valid,
  input  yrd_pkg::yrd_row_t                head_row,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [yrd_pkg::CLASS_W-1:0]       class_index,
  output logic [yrd_pkg::SCORE_W-1:0]       best_score,
  output logic [yrd_pkg::EDGE_W-1:0]        box_left,
  output logic [yrd_pkg::EDGE_W-1:0]        box_top,
  output logic signed [yrd_pkg::SIZE_W-1:0] box_width,
  output logic signed [yrd_pkg::SIZE_W-1:0] box_height
);
  import yrd_pkg::*;

  localparam int EP_W = ELEM_W + 2 + 17;
  localparam int SP_W = ELEM_W + 17;
  localparam int LIM_W = 18;
  localparam int EDGE_SHIFT = FRAC_BITS + 13;
  localparam int SIZE_SHIFT = FRAC_BITS + 12;
  localparam logic [EP_W-1:0] EDGE_RND = (43'd1 << EDGE_SHIFT) - 43'd1;
  localparam logic [SP_W-1:0] SIZE_RND = (41'd1 << SIZE_SHIFT) - 41'd1;
  localparam logic signed [EP_W-1:0] EDGE_MAX = 43'sd65535;
  localparam logic signed [LIM_W-1:0] SIZE_MAX = 18'sd65535;
  localparam logic signed [LIM_W-1:0] SIZE_MIN = -18'sd65536;

  logic                     advance;

  logic                     b1_valid;
  logic [CLASS_W-1:0]       b1_class;
  logic [SCORE_W-1:0]       b1_score;
  logic signed [EP_W-1:0]   b1_edge_px;
  logic signed [EP_W-1:0]   b1_edge_py;
  logic signed [SP_W-1:0]   b1_size_px;
  logic signed [SP_W-1:0]   b1_size_py;

  logic                     b2_valid;
  logic [CLASS_W-1:0]       b2_class;
  logic [SCORE_W-1:0]       b2_score;
  logic [EDGE_W-1:0]        b2_edge_x;
  logic [EDGE_W-1:0]        b2_edge_y;
  logic signed [LIM_W-1:0]  b2_size_x;
  logic signed [LIM_W-1:0]  b2_size_y;

  logic signed [ELEM_W+1:0] num_x;
  logic signed [ELEM_W+1:0] num_y;
  logic signed [EP_W-1:0]   edge_tx;
  logic signed [EP_W-1:0]   edge_ty;
  logic signed [SP_W-1:0]   size_tx;
  logic signed [SP_W-1:0]   size_ty;
  logic [EDGE_W-1:0]        edge_x;
  logic [EDGE_W-1:0]        edge_y;
  logic signed [LIM_W-1:0]  lim_x;
  logic signed [LIM_W-1:0]  lim_y;
  logic signed [LIM_W-1:0]  fit_x;
  logic signed [LIM_W-1:0]  fit_y;
  logic signed [SIZE_W-1:0] sat_x;
  logic signed [SIZE_W-1:0] sat_y;

  // The back end moves unless the output register holds a word not yet taken.
  assign advance = !out_valid || out_ready;
  assign pop     = advance && head_valid;

  // Stage one: corner numerator 2*c - size, then both products with the scale.
  assign num_x = {head_row.center_x[ELEM_W-1], head_row.center_x, 1'b0}
               - {{2{head_row.raw_width[ELEM_W-1]}}, head_row.raw_width};
  assign num_y = {head_row.center_y[ELEM_W-1], head_row.center_y, 1'b0}
               - {{2{head_row.raw_height[ELEM_W-1]}}, head_row.raw_height};

  always_ff @(posedge clk) begin
    if (advance) begin
      b1_class   <= head_row.class_index;
      b1_score   <= head_row.best_score;
      b1_edge_px <= EP_W'(num_x) * EP_W'($signed({1'b0, cfg.scale_x}));
      b1_edge_py <= EP_W'(num_y) * EP_W'($signed({1'b0, cfg.scale_y}));
      b1_size_px <= SP_W'(head_row.raw_width) * SP_W'($signed({1'b0, cfg.scale_x}));
      b1_size_py <= SP_W'(head_row.raw_height) * SP_W'($signed({1'b0, cfg.scale_y}));
    end
  end

  // Stage two: shifts truncate toward zero; the corner is clamped to 0..65535.
  always_comb begin
    edge_tx = $signed(b1_edge_px + (b1_edge_px[EP_W-1] ? EDGE_RND : '0)) >>> EDGE_SHIFT;
    edge_ty = $signed(b1_edge_py + (b1_edge_py[EP_W-1] ? EDGE_RND : '0)) >>> EDGE_SHIFT;
    size_tx = $signed(b1_size_px + (b1_size_px[SP_W-1] ? SIZE_RND : '0)) >>> SIZE_SHIFT;
    size_ty = $signed(b1_size_py + (b1_size_py[SP_W-1] ? SIZE_RND : '0)) >>> SIZE_SHIFT;
    if (edge_tx[EP_W-1]) begin
      edge_x = '0;
    end else if (edge_tx > EDGE_MAX) begin
      edge_x = '1;
    end else begin
      edge_x = edge_tx[EDGE_W-1:0];
    end
    if (edge_ty[EP_W-1]) begin
      edge_y = '0;
    end else if (edge_ty > EDGE_MAX) begin
      edge_y = '1;
    end else begin
      edge_y = edge_ty[EDGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b2_class  <= b1_class;
      b2_score  <= b1_score;
      b2_edge_x <= edge_x;
      b2_edge_y <= edge_y;
      b2_size_x <= size_tx[LIM_W-1:0];
      b2_size_y <= size_ty[LIM_W-1:0];
    end
  end

  // Stage three: size limited to the image edge, then saturated to 17 bits.
  always_comb begin
    lim_x = $signed({4'd0, cfg.image_width}) - $signed({2'd0, b2_edge_x});
    lim_y = $signed({4'd0, cfg.image_height}) - $signed({2'd0, b2_edge_y});
    fit_x = (b2_size_x > lim_x) ? lim_x : b2_size_x;
    fit_y = (b2_size_y > lim_y) ? lim_y : b2_size_y;
    if (fit_x > SIZE_MAX) begin
      sat_x = SIZE_MAX[SIZE_W-1:0];
    end else if (fit_x < SIZE_MIN) begin
      sat_x = SIZE_MIN[SIZE_W-1:0];
    end else begin
      sat_x = fit_x[SIZE_W-1:0];
    end
    if (fit_y > SIZE_MAX) begin
      sat_y = SIZE_MAX[SIZE_W-1:0];
    end else if (fit_y < SIZE_MIN) begin
      sat_y = SIZE_MIN[SIZE_W-1:0];
    end else begin
      sat_y = fit_y[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      class_index <= b2_class;
      best_score  <= b2_score;
      box_left    <= b2_edge_x;
      box_top     <= b2_edge_y;
      box_width   <= sat_x;
      box_height  <= sat_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      b1_valid  <= head_valid;
      b2_valid  <= b1_valid;
      out_valid <= b2_valid;
    end
  end

endmodule

FILE: rtl/yolo_row_decode_core.sv
// Detection row decoder: tensor element words in, at most one box word per row out.
// Throughput: one element per cycle unless a finished row meets a full queue, set by the
// combinational score compare in the front end; result words can leave back to back, one
// per cycle while det.ready is high, through the three-stage box pipeline.
// Reset (rst, synchronous, active high) loads the register defaults and empties all stages.
// Depends on yrd_pkg, yrd_ifs, yrd_front, yrd_queue and yrd_back.
module yolo_row_decode_core (
  input  logic      clk,
  input  logic      rst,
  yrd_elem_if.sink  elem,
  yrd_det_if.source det,
  yrd_cfg_if.sink   cfg
);
  import yrd_pkg::*;

  yrd_cfg_t regs;
  logic     q_full;
  logic     q_push;
  yrd_row_t q_push_row;
  logic     q_head_valid;
  logic     q_pop;
  yrd_row_t q_head_row;

  // The register file takes a word every cycle. Indexes beyond the list are ignored,
  // and each value is cut to its register's width.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.decode_mode    <= 1'b0;
      regs.conf_threshold <= 13'd1024;
      regs.image_width    <= 14'd640;
      regs.image_height   <= 14'd640;
      regs.scale_x        <= 16'd4096;
      regs.scale_y        <= 16'd4096;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DECODE_MODE:    regs.decode_mode    <= cfg.data[0];
        REG_CONF_THRESHOLD: regs.conf_threshold <= cfg.data[12:0];
        REG_IMAGE_WIDTH:    regs.image_width    <= cfg.data[13:0];
        REG_IMAGE_HEIGHT:   regs.image_height   <= cfg.data[13:0];
        REG_SCALE_X:        regs.scale_x        <= cfg.data;
        REG_SCALE_Y:        regs.scale_y        <= cfg.data;
        default: ;
      endcase
    end
  end

  // The front end tracks the element position, captures the box and objectness
  // elements, and keeps the first strictly greatest positive class score. On a row's last
  // element it decides whether the row is kept and, if so, queues it.
  yrd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (regs),
    .in_valid      (elem.valid),
    .in_ready      (elem.ready),
    .element_value (elem.element_value),
    .row_last      (elem.row_last),
    .q_full        (q_full),
    .push          (q_push),
    .push_row      (q_push_row)
  );

  // The queue lets the element stream continue while box words wait on the output.
  yrd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_row   (q_push_row),
    .full       (q_full),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .head_row   (q_head_row)
  );

  // The back end scales the box, clamps the corner and limits the size to the image.
  yrd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (regs),
    .head_valid  (q_head_valid),
    .head_row    (q_head_row),
    .pop         (q_pop),
    .out_valid   (det.valid),
    .out_ready   (det.ready),
    .class_index (det.class_index),
    .best_score  (det.best_score),
    .box_left    (det.box_left),
    .box_top     (det.box_top),
    .box_width   (det.box_width),
    .box_height  (det.box_height)
  );

endmodule
